@@ design/smq_pkg.sv @@
// smq_pkg: shared types and constants of the speed motion qualifier.
// Used by smq_filter, smq_qualify, the top level and the testbench; no dependencies.

package smq_pkg;

  // Alpha fraction bits: 1 << ALPHA_FRAC_BITS stands for a weight of 1.0.
  localparam int ALPHA_FRAC_BITS = 16;
  localparam int ALPHA_REG_W     = 17;
  // Working width of alpha and one minus alpha.
  localparam int ALPHA_W = (ALPHA_FRAC_BITS + 1 > ALPHA_REG_W) ?
                           ALPHA_FRAC_BITS + 1 : ALPHA_REG_W;

  localparam int FILT_W = 32;  // Q16.16 average in 0.01 km/h

  // Register indexes on the configuration port.
  localparam logic [1:0] CFG_SMOOTHING_ALPHA  = 2'd0;
  localparam logic [1:0] CFG_MOVE_THRESHOLD   = 2'd1;
  localparam logic [1:0] CFG_STOP_THRESHOLD   = 2'd2;
  localparam logic [1:0] CFG_MOVE_COUNT_LIMIT = 2'd3;

  localparam logic [16:0] ALPHA_RESET      = 17'd13107;
  localparam logic [15:0] MOVE_THR_RESET   = 16'd500;
  localparam logic [15:0] STOP_THR_RESET   = 16'd200;
  localparam logic [7:0]  COUNT_LIM_RESET  = 8'd3;

  localparam logic [7:0]  MIN_SATELLITES     = 8'd4;
  localparam logic [15:0] LOW_SPEED_CENTI    = 16'd300;
  localparam logic signed [14:0] G_DEADBAND  = 15'sd100;
  localparam logic signed [18:0] YAW_DEADBAND = 19'sd300;

  // Divide by 10 as multiply by ceil(2^19 / 10) and shift; exact below 2^18.
  localparam logic [15:0] DIV10_MUL   = 16'd52429;
  localparam int          DIV10_SHIFT = 19;

  typedef struct packed {
    logic [16:0] smoothing_alpha;
    logic [15:0] move_threshold;
    logic [15:0] stop_threshold;
    logic [7:0]  move_count_limit;
  } cfg_t;

  typedef struct packed {
    logic [15:0]        speed_raw;
    logic               location_valid;
    logic [7:0]         satellite_count;
    logic signed [14:0] dynamic_g;
    logic signed [18:0] yaw_rate;
  } fix_t;

  // Between the filter stage and the qualifier stage.
  typedef struct packed {
    logic              usable;
    logic              imu_quiet;
    logic [FILT_W-1:0] avg;
  } mid_t;

  typedef struct packed {
    logic [12:0] speed_tenths;
    logic        moving;
  } res_t;

endpackage

@@ design/smq_filter.sv @@
// smq_filter: input register, fix screening and exponential average update.
// Depends on smq_pkg.

module smq_filter (
  input  logic          clk,
  input  logic          rst,
  input  smq_pkg::cfg_t cfg,
  input  logic          in_valid,
  output logic          in_ready,
  input  smq_pkg::fix_t in_fix,
  output logic          mid_valid,
  input  logic          mid_take,
  output smq_pkg::mid_t mid
);
  import smq_pkg::*;

  localparam int ACC_W = ALPHA_W + FILT_W + 1;

  logic              fix_valid;
  fix_t              fix;
  logic [FILT_W-1:0] filtered_speed;
  logic [FILT_W-1:0] filtered_speed_next;

  logic               advance;
  logic               mid_free;
  logic               usable;
  logic [ALPHA_W-1:0] alpha_ext;
  logic [ALPHA_W-1:0] alpha_one;
  logic [ALPHA_W-1:0] alpha_c;
  logic [ALPHA_W-1:0] beta;
  logic [ACC_W-1:0]   acc;

  assign mid_free = !mid_valid || mid_take;
  assign advance  = fix_valid && mid_free;
  assign in_ready = !fix_valid || advance;

  assign usable = fix.location_valid && (fix.satellite_count >= MIN_SATELLITES);

  always_comb begin
    alpha_ext = ALPHA_W'(cfg.smoothing_alpha);
    alpha_one = ALPHA_W'(1) << ALPHA_FRAC_BITS;
    alpha_c   = (alpha_ext > alpha_one) ? alpha_one : alpha_ext;
    beta      = alpha_one - alpha_c;
    acc = ((ACC_W'(alpha_c) * ACC_W'(fix.speed_raw)) << 16)
        + ACC_W'(beta) * ACC_W'(filtered_speed)
        + (ACC_W'(alpha_one) >> 1);
    filtered_speed_next = acc[ALPHA_FRAC_BITS +: FILT_W];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fix_valid      <= 1'b0;
      mid_valid      <= 1'b0;
      filtered_speed <= '0;
    end else begin
      if (in_ready) begin
        fix_valid <= in_valid;
      end
      if (mid_free) begin
        mid_valid <= fix_valid;
      end
      if (advance && usable) begin
        filtered_speed <= filtered_speed_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      fix <= in_fix;
    end
    if (advance) begin
      mid.usable    <= usable;
      mid.imu_quiet <= (fix.dynamic_g > -G_DEADBAND) && (fix.dynamic_g < G_DEADBAND) &&
                       (fix.yaw_rate > -YAW_DEADBAND) && (fix.yaw_rate < YAW_DEADBAND);
      mid.avg       <= filtered_speed_next;
    end
  end

endmodule

@@ design/smq_qualify.sv @@
// smq_qualify: fast-fix counter, motion decision, rounding to 0.1 km/h, output register.
// Depends on smq_pkg.

module smq_qualify (
  input  logic          clk,
  input  logic          rst,
  input  smq_pkg::cfg_t cfg,
  input  logic          mid_valid,
  output logic          mid_take,
  input  smq_pkg::mid_t mid,
  output logic          res_valid,
  input  logic          res_ready,
  output smq_pkg::res_t res
);
  import smq_pkg::*;

  logic [7:0]  fast_count;
  logic [7:0]  fast_count_next;
  logic [8:0]  count_inc;
  logic        moving;
  logic [32:0] rounded;
  logic [16:0] whole;
  logic [32:0] scaled;

  assign mid_take = mid_valid && (!res_valid || res_ready);

  always_comb begin
    count_inc = {1'b0, fast_count} + 9'd1;
    priority if (mid.avg >= {cfg.move_threshold, 16'h0000}) begin
      fast_count_next = (count_inc < {1'b0, cfg.move_count_limit}) ?
                        count_inc[7:0] : cfg.move_count_limit;
    end else if (mid.avg <= {cfg.stop_threshold, 16'h0000}) begin
      fast_count_next = '0;
    end else begin
      // between the thresholds: counter holds
      fast_count_next = fast_count;
    end
    moving = (fast_count_next >= cfg.move_count_limit) &&
             !((mid.avg < {LOW_SPEED_CENTI, 16'h0000}) && mid.imu_quiet);
    // (avg + 5.0) / 10.0 in Q16.16, floored: whole units first, then divide by 10
    rounded = {1'b0, mid.avg} + 33'h5_0000;
    whole   = rounded[32:16];
    scaled  = 33'(whole) * 33'(DIV10_MUL);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid  <= 1'b0;
      fast_count <= '0;
    end else begin
      if (mid_take) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
      if (mid_take && mid.usable) begin
        fast_count <= fast_count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mid_take) begin
      res.moving       <= mid.usable && moving;
      res.speed_tenths <= (mid.usable && moving) ? scaled[DIV10_SHIFT +: 13] : '0;
    end
  end

endmodule

@@ design/speed_motion_qualifier.sv @@
// speed_motion_qualifier: top level; configuration registers and the two stages.
// Depends on smq_pkg, smq_filter and smq_qualify.
//
// Path: each fix goes through the input register, the mid register and the output register.
// Throughput: one fix per cycle while the result stream is not stalled; the average update
//   (filter stage) and the counter update (qualifier stage) each feed back from their own register.
// Reset (rst, synchronous): pipeline emptied, average and counter cleared,
//   registers back to alpha 13107, thresholds 500 / 200, count limit 3.

module speed_motion_qualifier (
  input  logic        clk,
  input  logic        rst,
  // configuration writes
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [16:0] cfg_data,
  // fix stream in
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [15:0] speed_raw, [23:16] satellite_count, [38:24] dynamic_g,
  // [57:39] yaw_rate, [63:58] zero
  input  logic [63:0] s_axis_tdata,
  // [0] location_valid
  input  logic        s_axis_tuser,
  // result stream out
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [12:0] speed_tenths, [13] moving, [15:14] zero
  output logic [15:0] m_axis_tdata
);
  import smq_pkg::*;

  cfg_t cfg;
  fix_t in_fix;
  mid_t mid;
  res_t res;
  logic mid_valid;
  logic mid_take;

  // The user must write the registers only while the block is idle; the block itself does not enforce this.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.smoothing_alpha  <= ALPHA_RESET;
      cfg.move_threshold   <= MOVE_THR_RESET;
      cfg.stop_threshold   <= STOP_THR_RESET;
      cfg.move_count_limit <= COUNT_LIM_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SMOOTHING_ALPHA:  cfg.smoothing_alpha  <= cfg_data;
        CFG_MOVE_THRESHOLD:   cfg.move_threshold   <= cfg_data[15:0];
        CFG_STOP_THRESHOLD:   cfg.stop_threshold   <= cfg_data[15:0];
        CFG_MOVE_COUNT_LIMIT: cfg.move_count_limit <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Unpack the incoming transfer.
  assign in_fix.speed_raw       = s_axis_tdata[15:0];
  assign in_fix.satellite_count = s_axis_tdata[23:16];
  assign in_fix.dynamic_g       = s_axis_tdata[38:24];
  assign in_fix.yaw_rate        = s_axis_tdata[57:39];
  assign in_fix.location_valid  = s_axis_tuser;

  // Stage 1: input register, screening, average update (owns the average).
  smq_filter u_filter (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_fix    (in_fix),
    .mid_valid (mid_valid),
    .mid_take  (mid_take),
    .mid       (mid)
  );

  // Stage 2: hysteresis counter, motion decision, output register.
  smq_qualify u_qualify (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .mid_valid (mid_valid),
    .mid_take  (mid_take),
    .mid       (mid),
    .res_valid (m_axis_tvalid),
    .res_ready (m_axis_tready),
    .res       (res)
  );

  assign m_axis_tdata = {2'b00, res.moving, res.speed_tenths};

endmodule

@@ design/smq_checker.sv @@
// smq_port_checker: port-level assertions for speed_motion_qualifier, bound to the top.
// Depends on speed_motion_qualifier's ports only.

module smq_port_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata
);

  // A nonzero speed is only reported while moving.
  a_speed_needs_motion: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && (m_axis_tdata[12:0] != 13'd0)) |-> m_axis_tdata[13])
    else $error("speed reported while not moving");

  // Average never tops 655.35 km/h, so the result stays within 6554.
  a_speed_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[12:0] <= 13'd6554))
    else $error("speed_tenths out of range");

  // When the output side can move, the input side never stalls.
  a_no_false_stall: assert property (@(posedge clk) disable iff (rst)
    (!m_axis_tvalid || m_axis_tready) |-> s_axis_tready)
    else $error("input stalled with output free");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result present after reset");

  // Held result stays put.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled result changed");

endmodule

bind speed_motion_qualifier smq_port_checker u_smq_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

@@ tb/smq_checker.sv @@
// smq_checker: scoreboard for the speed motion qualifier. Mirrors the register
// writes, predicts one result per fix transfer and compares the result stream.
// Depends on smq_pkg.
`timescale 1ns / 100ps

module smq_checker
  import smq_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [16:0] cfg_data,
  input  logic        fix_valid,
  input  logic        fix_ready,
  input  logic [63:0] fix_data,
  input  logic        fix_user,
  input  logic        res_valid,
  input  logic        res_ready,
  input  logic [15:0] res_data,
  output int          fault_count,
  output int          results_due
);

  cfg_t        regs;
  logic [31:0] avg_q1616;   // Q16.16 average, 0.01 km/h
  logic [7:0]  fast_cnt;
  res_t        speed_due[$];

  function automatic void log_fault(input string what);
    if (fault_count < 10) $display("%0t: %s", $time, what);
    fault_count++;
  endfunction

  // One fix through the filter and the motion hysteresis.
  function automatic res_t qualify_fix(input logic [15:0] raw, input logic loc_ok,
                                       input logic [7:0] sats,
                                       input logic signed [14:0] g,
                                       input logic signed [18:0] yaw);
    logic [63:0] one, alpha, acc;
    logic [8:0]  bumped;
    int          g_mag, yaw_mag;
    logic        moving;
    res_t        r;
    r = '0;
    if (!loc_ok || sats < MIN_SATELLITES) return r;  // state untouched
    one   = 64'd1 << ALPHA_FRAC_BITS;
    alpha = (64'(regs.smoothing_alpha) > one) ? one : 64'(regs.smoothing_alpha);
    acc   = alpha * (64'(raw) << 16) + (one - alpha) * 64'(avg_q1616) + (one >> 1);
    avg_q1616 = 32'(acc >> ALPHA_FRAC_BITS);

    if (avg_q1616 >= {regs.move_threshold, 16'h0}) begin
      bumped   = fast_cnt + 9'd1;
      fast_cnt = (bumped < regs.move_count_limit) ? bumped[7:0] : regs.move_count_limit;
    end else if (avg_q1616 <= {regs.stop_threshold, 16'h0}) begin
      fast_cnt = '0;
    end

    moving  = (fast_cnt >= regs.move_count_limit);
    g_mag   = (g < 0) ? -int'(g) : int'(g);
    yaw_mag = (yaw < 0) ? -int'(yaw) : int'(yaw);
    if (avg_q1616 < {LOW_SPEED_CENTI, 16'h0} && g_mag < int'(G_DEADBAND) &&
        yaw_mag < int'(YAW_DEADBAND))
      moving = 1'b0;

    if (moving) begin
      r.speed_tenths = 13'((64'(avg_q1616) + (64'd5 << 16)) / (64'd10 << 16));
      r.moving       = 1'b1;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    res_t got, want;
    if (rst) begin
      regs.smoothing_alpha  = ALPHA_RESET;
      regs.move_threshold   = MOVE_THR_RESET;
      regs.stop_threshold   = STOP_THR_RESET;
      regs.move_count_limit = COUNT_LIM_RESET;
      avg_q1616 = '0;
      fast_cnt  = '0;
      speed_due.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_SMOOTHING_ALPHA:  regs.smoothing_alpha  = cfg_data;
          CFG_MOVE_THRESHOLD:   regs.move_threshold   = cfg_data[15:0];
          CFG_STOP_THRESHOLD:   regs.stop_threshold   = cfg_data[15:0];
          CFG_MOVE_COUNT_LIMIT: regs.move_count_limit = cfg_data[7:0];
          default: ;
        endcase
      end

      if (res_valid && res_ready) begin
        got.speed_tenths = res_data[12:0];
        got.moving       = res_data[13];
        if (speed_due.size() == 0) begin
          log_fault($sformatf("result with nothing pending: speed_tenths %0d moving %0b",
                              got.speed_tenths, got.moving));
        end else begin
          want = speed_due.pop_front();
          if (got.speed_tenths !== want.speed_tenths)
            log_fault($sformatf("speed_tenths expected %0d got %0d",
                                want.speed_tenths, got.speed_tenths));
          if (got.moving !== want.moving)
            log_fault($sformatf("moving expected %0b got %0b", want.moving, got.moving));
        end
      end

      if (fix_valid && fix_ready)
        speed_due.push_back(qualify_fix(fix_data[15:0], fix_user, fix_data[23:16],
                                        fix_data[38:24], fix_data[57:39]));
    end
    results_due = speed_due.size();
  end

endmodule

@@ tb/tb_speed_motion_qualifier.sv @@
// tb_speed_motion_qualifier: stimulus and verdict for the speed motion qualifier.
// Drives fixes, register writes and result back-pressure; smq_checker does the
// prediction. Depends on smq_pkg, smq_checker and speed_motion_qualifier.
`timescale 1ns / 100ps

module tb_speed_motion_qualifier;
  import smq_pkg::*;

  localparam int CYCLE_LIMIT = 400000;  // far beyond the slowest correct run
  localparam int HOLD_CYCLES = 150;     // long sink stall to back up the pipe
  localparam int PHASE_FIXES = 125;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [16:0] cfg_data = '0;
  logic        s_valid = 1'b0;
  logic        s_ready;
  logic [63:0] s_data = '0;
  logic        s_user = 1'b0;
  logic        m_valid;
  logic        m_ready = 1'b0;
  logic [15:0] m_data;

  int fault_count;
  int results_due;
  int cycles = 0;

  // Flow-control knobs shared between the stimulus and the result sink.
  bit feed_calm = 1'b0;  // sender runs back-to-back while set
  bit sink_calm = 1'b0;  // sink ready without gaps while set, except during a hold_off stall
  bit rush      = 1'b0;  // force back-to-back fixes (pressure test)
  bit hold_off  = 1'b0;  // ask the sink for one long stall

  // Copies of the thresholds, used to aim speeds around them.
  int cur_move = 500;
  int cur_stop = 200;

  speed_motion_qualifier dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_ready),
    .s_axis_tdata  (s_data),
    .s_axis_tuser  (s_user),
    .m_axis_tvalid (m_valid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_data)
  );

  smq_checker chk (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .fix_valid   (s_valid),
    .fix_ready   (s_ready),
    .fix_data    (s_data),
    .fix_user    (s_user),
    .res_valid   (m_valid),
    .res_ready   (m_ready),
    .res_data    (m_data),
    .fault_count (fault_count),
    .results_due (results_due)
  );

  always #6 clk = ~clk;

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("speed_motion_qualifier: mismatch");
      $finish;
    end
  end

  // One fix transfer. Entered and left at a falling edge; valid is left high
  // so back-to-back fixes never drop it within one step.
  task automatic push_fix(input logic [15:0] raw, input logic loc_ok,
                          input logic [7:0] sats, input logic signed [14:0] g,
                          input logic signed [18:0] yaw);
    int gap;
    if ($urandom_range(0, 29) == 0) feed_calm = !feed_calm;
    gap = (feed_calm || rush) ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      s_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_valid <= 1'b1;
    // tdata: [15:0] speed_raw, [23:16] satellite_count, [38:24] dynamic_g,
    // [57:39] yaw_rate; tuser: location_valid
    s_data  <= {6'b0, yaw, g, sats, raw};
    s_user  <= loc_ok;
    @(posedge clk);
    while (!s_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Stop offering fixes and wait until every result is back.
  task automatic wait_until_drained();
    s_valid <= 1'b0;
    while (results_due != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [16:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_regs(input logic [16:0] alpha, input logic [15:0] move_thr,
                          input logic [15:0] stop_thr, input logic [7:0] count_lim);
    write_reg(CFG_SMOOTHING_ALPHA, alpha);
    write_reg(CFG_MOVE_THRESHOLD, {1'b0, move_thr});
    write_reg(CFG_STOP_THRESHOLD, {1'b0, stop_thr});
    write_reg(CFG_MOVE_COUNT_LIMIT, {9'b0, count_lim});
    cur_move = int'(move_thr);
    cur_stop = int'(stop_thr);
  endtask

  // Random drives: segments of steady speed aimed above the move threshold,
  // below the stop threshold, between them, at walking pace or anywhere,
  // with IMU noise and a share of unusable fixes mixed in.
  task automatic run_trips(input int n_fixes);
    int         left, seg, kind, base, sp, j, gi, yi;
    logic       loc_ok;
    logic [7:0] sats;
    left = n_fixes;
    while (left > 0) begin
      seg = $urandom_range(3, 25);
      if (seg > left) seg = left;
      left -= seg;
      kind = $urandom_range(0, 5);
      case (kind)
        0: base = cur_move + $urandom_range(0, 300);
        1: base = cur_stop - $urandom_range(0, 300);
        2: base = (cur_move + cur_stop) / 2;
        3: base = $urandom_range(0, 400);
        default: base = $urandom_range(0, 65535);
      endcase
      repeat (seg) begin
        if (kind == 5) begin
          sp = $urandom_range(0, 65535);
        end else begin
          j  = $urandom_range(0, 60);
          sp = base + j - 30;
        end
        if (sp < 0) sp = 0;
        if (sp > 65535) sp = 65535;

        case ($urandom_range(0, 3))
          0, 1: begin  // quiet IMU
            gi = $urandom_range(0, 198);
            gi -= 99;
            yi = $urandom_range(0, 598);
            yi -= 299;
          end
          2: begin     // right at the deadband edges
            gi = $urandom_range(0, 1) ? 99 : 100;
            yi = $urandom_range(0, 1) ? 299 : 300;
            if ($urandom_range(0, 1)) gi = -gi;
            if ($urandom_range(0, 1)) yi = -yi;
          end
          default: begin  // any bit pattern
            gi = $urandom();
            yi = $urandom();
          end
        endcase

        if ($urandom_range(0, 99) < 12) begin
          // unusable: no location, or too few satellites
          loc_ok = 1'($urandom_range(0, 1));
          sats   = loc_ok ? 8'($urandom_range(0, 3)) : 8'($urandom_range(0, 255));
        end else begin
          loc_ok = 1'b1;
          sats   = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(4, 255)) :
                                                 8'($urandom_range(4, 14));
        end
        push_fix(16'(sp), loc_ok, sats, 15'(gi), 19'(yi));
      end
    end
  endtask

  // Result sink: random ready gaps, calm stretches, and one long stall on demand.
  initial begin : result_sink
    int gap;
    while (rst) @(negedge clk);
    forever begin
      if (hold_off) begin
        m_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_off = 1'b0;
      end else begin
        if ($urandom_range(0, 29) == 0) sink_calm = !sink_calm;
        gap = sink_calm ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
          m_ready <= 1'b0;
          repeat (gap) @(negedge clk);
        end
      end
      m_ready <= 1'b1;
      @(posedge clk);
      while (!m_valid) @(posedge clk);
      @(negedge clk);
    end
  end

  initial begin : stimulus
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Unusable fixes: no location, too few satellites, field extremes.
    push_fix(16'hFFFF, 1'b0, 8'd12, 15'h0, 19'h0);
    push_fix(16'hFFFF, 1'b1, 8'd3, 15'h0, 19'h0);
    push_fix(16'hFFFF, 1'b1, 8'd0, 15'd5000, 19'h0);
    push_fix(16'h0000, 1'b0, 8'hFF, 15'h4000, 19'h40000);
    // Top speed at the minimum satellite count: counter climbs to its limit.
    repeat (6) push_fix(16'hFFFF, 1'b1, 8'd4, 15'h0, 19'h0);

    // Alpha of one makes the average follow each fix exactly, so the
    // low-speed suppression and the rounding can be aimed at directly.
    wait_until_drained();
    set_regs(17'd65536, MOVE_THR_RESET, STOP_THR_RESET, COUNT_LIM_RESET);
    push_fix(16'd250, 1'b1, 8'd8, 15'sd0, 19'sd0);       // quiet: suppressed
    push_fix(16'd250, 1'b1, 8'd8, 15'sd99, 19'sd0);      // still inside deadband
    push_fix(16'd250, 1'b1, 8'd8, 15'sd100, 19'sd0);     // g at deadband: moving
    push_fix(16'd250, 1'b1, 8'd8, -15'sd99, -19'sd299);  // suppressed
    push_fix(16'd250, 1'b1, 8'd8, -15'sd100, 19'sd0);    // moving
    push_fix(16'd250, 1'b1, 8'd8, 15'sd0, 19'sd299);     // suppressed
    push_fix(16'd250, 1'b1, 8'd8, 15'sd0, -19'sd300);    // yaw at deadband: moving
    push_fix(16'd255, 1'b1, 8'd8, 15'h3FFF, 19'h3FFFF);  // rounds half up
    push_fix(16'd300, 1'b1, 8'd8, 15'sd0, 19'sd0);       // 3 km/h is not low speed
    push_fix(16'd299, 1'b1, 8'd8, 15'sd0, 19'sd0);       // just under: suppressed
    push_fix(16'd200, 1'b1, 8'd8, 15'sd1000, 19'sd0);    // at stop threshold: clears
    push_fix(16'd500, 1'b1, 8'd8, 15'sd1000, 19'sd0);    // one fast fix only

    // Register settings per phase: reset values, extremes, fixed mid-range ones, then random ones.
    for (int ph = 0; ph < 9; ph++) begin
      wait_until_drained();
      case (ph)
        0: set_regs(ALPHA_RESET, MOVE_THR_RESET, STOP_THR_RESET, COUNT_LIM_RESET);
        1: set_regs(17'd65536, 16'd0, 16'd0, 8'd1);
        2: set_regs(17'h1FFFF, 16'hFFFF, 16'hFFFF, 8'hFF);  // alpha above one
        3: set_regs(17'd0, 16'd100, 16'd50, 8'd0);          // frozen average, no limit
        4: set_regs(17'd1, 16'd3000, 16'd1000, 8'd2);
        5: set_regs(17'd32768, 16'd800, 16'd400, 8'd5);
        default: begin
          cur_move = $urandom_range(0, 8000);
          set_regs(17'($urandom_range(0, 70000)), 16'(cur_move),
                   16'($urandom_range(0, cur_move)), 8'($urandom_range(0, 12)));
        end
      endcase
      if (ph == 1 || ph == 6) begin
        // Sender back-to-back while the sink stalls: the pipe fills and
        // s_axis_tready must drop.
        rush     = 1'b1;
        hold_off = 1'b1;
        run_trips(40);
        rush     = 1'b0;
        run_trips(PHASE_FIXES - 40);
      end else begin
        run_trips(PHASE_FIXES);
      end
    end

    wait_until_drained();
    repeat (4) @(negedge clk);
    if (fault_count == 0 && results_due == 0) begin
      $display("speed_motion_qualifier: match");
    end else begin
      $display("speed_motion_qualifier: mismatch");
    end
    $finish;
  end

endmodule
